### hw/rtl/integer_to_roman_numeral_defines.svh
// Assertion macros for the integer to Roman numeral block.
// Included by the top level; needs nothing else.
`ifndef INTEGER_TO_ROMAN_NUMERAL_DEFINES_SVH
`define INTEGER_TO_ROMAN_NUMERAL_DEFINES_SVH

`ifndef SYNTH
// Check that a property holds at every clock edge outside reset.
`define I2R_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("i2r assertion failed");
// Check that a condition never occurs outside reset.
`define I2R_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("i2r forbidden condition seen");
`else
`define I2R_ASSERT(label, clk, rst_n, prop)
`define I2R_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

### hw/rtl/i2r_pkg.sv
// Types, letter codes and the microcode table of the integer to Roman numeral block.
// No dependencies.
package i2r_pkg;

  localparam int unsigned ValW  = 12;
  localparam int unsigned CharW = 8;
  localparam int unsigned AmtW  = 10;

  localparam logic [CharW-1:0] CH_M  = 8'h4D;
  localparam logic [CharW-1:0] CH_D  = 8'h44;
  localparam logic [CharW-1:0] CH_C  = 8'h43;
  localparam logic [CharW-1:0] CH_L  = 8'h4C;
  localparam logic [CharW-1:0] CH_X  = 8'h58;
  localparam logic [CharW-1:0] CH_V  = 8'h56;
  localparam logic [CharW-1:0] CH_I  = 8'h49;
  localparam logic [CharW-1:0] CH_NL = 8'h0A;

  // Program addresses. Two-letter subtractive forms take two steps.
  typedef enum logic [4:0] {
    S_M, S_CM_C, S_CM_M, S_D, S_CD_C, S_CD_D, S_C,
    S_XC_X, S_XC_C, S_L, S_XL_X, S_XL_L, S_X,
    S_IX_I, S_IX_X, S_V, S_IV_I, S_IV_V, S_I,
    S_NL
  } step_e;

  // One control word: test value >= amount (else jump to fail_step), emit ch,
  // optionally subtract amount, then go to pass_step.
  typedef struct packed {
    logic             test;
    logic             sub;
    logic             last;
    logic [AmtW-1:0]  amount;
    logic [CharW-1:0] ch;
    step_e            pass_step;
    step_e            fail_step;
  } ucode_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic  busy;
    logic  emit;
    logic  last;
    step_e step;
  } seq_stat_t;

  function automatic ucode_t uw(logic test, logic sub, logic last, logic [AmtW-1:0] amount,
                                logic [CharW-1:0] ch, step_e pass_step, step_e fail_step);
    ucode_t w;
    w.test      = test;
    w.sub       = sub;
    w.last      = last;
    w.amount    = amount;
    w.ch        = ch;
    w.pass_step = pass_step;
    w.fail_step = fail_step;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(step_e s);
    ucode_t w;
    unique case (s)
      S_M:     w = uw(1'b1, 1'b1, 1'b0, 10'd1000, CH_M, S_M,    S_CM_C);
      S_CM_C:  w = uw(1'b1, 1'b0, 1'b0, 10'd900,  CH_C, S_CM_M, S_D);
      S_CM_M:  w = uw(1'b0, 1'b1, 1'b0, 10'd900,  CH_M, S_XC_X, S_XC_X);
      S_D:     w = uw(1'b1, 1'b1, 1'b0, 10'd500,  CH_D, S_C,    S_CD_C);
      S_CD_C:  w = uw(1'b1, 1'b0, 1'b0, 10'd400,  CH_C, S_CD_D, S_C);
      S_CD_D:  w = uw(1'b0, 1'b1, 1'b0, 10'd400,  CH_D, S_XC_X, S_XC_X);
      S_C:     w = uw(1'b1, 1'b1, 1'b0, 10'd100,  CH_C, S_C,    S_XC_X);
      S_XC_X:  w = uw(1'b1, 1'b0, 1'b0, 10'd90,   CH_X, S_XC_C, S_L);
      S_XC_C:  w = uw(1'b0, 1'b1, 1'b0, 10'd90,   CH_C, S_IX_I, S_IX_I);
      S_L:     w = uw(1'b1, 1'b1, 1'b0, 10'd50,   CH_L, S_X,    S_XL_X);
      S_XL_X:  w = uw(1'b1, 1'b0, 1'b0, 10'd40,   CH_X, S_XL_L, S_X);
      S_XL_L:  w = uw(1'b0, 1'b1, 1'b0, 10'd40,   CH_L, S_IX_I, S_IX_I);
      S_X:     w = uw(1'b1, 1'b1, 1'b0, 10'd10,   CH_X, S_X,    S_IX_I);
      S_IX_I:  w = uw(1'b1, 1'b0, 1'b0, 10'd9,    CH_I, S_IX_X, S_V);
      S_IX_X:  w = uw(1'b0, 1'b1, 1'b0, 10'd9,    CH_X, S_NL,   S_NL);
      S_V:     w = uw(1'b1, 1'b1, 1'b0, 10'd5,    CH_V, S_I,    S_IV_I);
      S_IV_I:  w = uw(1'b1, 1'b0, 1'b0, 10'd4,    CH_I, S_IV_V, S_I);
      S_IV_V:  w = uw(1'b0, 1'b1, 1'b0, 10'd4,    CH_V, S_NL,   S_NL);
      S_I:     w = uw(1'b1, 1'b1, 1'b0, 10'd1,    CH_I, S_I,    S_NL);
      S_NL:    w = uw(1'b0, 1'b0, 1'b1, 10'd0,    CH_NL, S_M,   S_M);
      default: w = uw(1'b0, 1'b0, 1'b1, 10'd0,    CH_NL, S_M,   S_M);
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/i2r_dpath.sv
// Datapath of the integer to Roman numeral block: remaining value, compare, subtract.
// Depends on i2r_pkg.
module i2r_dpath
  import i2r_pkg::*;
(
  input  logic            clk,
  input  logic            load,
  input  logic [ValW-1:0] load_value,
  input  logic            step,
  input  ucode_t          uc,
  output logic            ge
);

  logic [ValW-1:0] value_r;
  logic [ValW-1:0] value_nxt;
  logic [ValW-1:0] amount_ext;

  assign amount_ext = {{(ValW-AmtW){1'b0}}, uc.amount};
  assign ge         = (value_r >= amount_ext);

  always_comb begin
    value_nxt = value_r;
    if (load) begin
      value_nxt = load_value;
    end else if (step && uc.sub) begin
      value_nxt = value_r - amount_ext;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

### hw/rtl/i2r_seq.sv
// Microcode sequencer: step register, control word lookup and conditional jumps.
// Depends on i2r_pkg.
module i2r_seq
  import i2r_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      ge,
  input  logic      emit_ok,
  output ucode_t    uc,
  output seq_stat_t stat
);

  step_e step_r, step_nxt;
  logic  busy_r, busy_nxt;
  logic  take;
  logic  emit;

  assign uc   = ucode_rom(step_r);
  assign take = uc.test ? ge : 1'b1;

  // Output decode
  always_comb begin
    emit      = busy_r && take && emit_ok;
    stat.busy = busy_r;
    stat.emit = emit;
    stat.last = uc.last;
    stat.step = step_r;
  end

  // Next step
  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (start) begin
      step_nxt = S_M;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!take) begin
        step_nxt = uc.fail_step;
      end else if (emit_ok) begin
        step_nxt = uc.pass_step;
        if (uc.last) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_M;
      busy_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

### hw/rtl/integer_to_roman_numeral.sv
// Channel  | Ports                                  | Carries
// ---------+----------------------------------------+-------------------------------
// input    | in_valid, in_ready, in_value[11:0]     | one binary integer per transfer
// result   | out_valid, out_ready, out_char_code,   | one ASCII letter per transfer,
//          | out_last                               | newline with out_last closes run
//
// Run: an item takes its transfer, then one microcode step per letter, one per newline and
// one per failed microcode test (at most thirteen); 3333 is the slowest value up to 3999,
// and values above it are written with four Ms. The single microcode sequencer and its
// step-by-step program set this timing.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// Stalls: the sequencer holds a letter while the output register is full and out_ready is low;
// in_ready stays low until the closing newline has been produced.
//
// Depends on i2r_pkg, i2r_seq, i2r_dpath and integer_to_roman_numeral_defines.svh.
`include "integer_to_roman_numeral_defines.svh"

module integer_to_roman_numeral
  import i2r_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ValW-1:0]  in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CharW-1:0] out_char_code,
  output logic             out_last
);

  ucode_t          uc;
  seq_stat_t       stat;
  logic            ge;
  logic            start;
  logic            emit_ok;
  logic            out_valid_r, out_valid_nxt;
  logic [CharW-1:0] out_char_code_r;
  logic            out_last_r;

  // Take a new value only once the previous run has produced its newline.
  assign in_ready = !stat.busy;
  assign start    = in_valid && in_ready;

  // The output register frees up when empty or when its letter transfers.
  assign emit_ok = !out_valid_r || out_ready;

  i2r_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .ge      (ge),
    .emit_ok (emit_ok),
    .uc      (uc),
    .stat    (stat)
  );

  // Subtract the step's amount only on the cycle its letter is emitted.
  i2r_dpath u_dpath (
    .clk        (clk),
    .load       (start),
    .load_value (in_value),
    .step       (stat.emit),
    .uc         (uc),
    .ge         (ge)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stat.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: load on emit, hold otherwise.
  always_ff @(posedge clk) begin
    if (stat.emit) begin
      out_char_code_r <= uc.ch;
      out_last_r      <= uc.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_code_r;
  assign out_last      = out_last_r;

  // A new run always starts at the thousands step.
  `I2R_ASSERT(a_start_at_top, clk, rst_n, start |=> (stat.busy && stat.step == S_M))
  // Emitting the newline ends the run.
  `I2R_ASSERT(a_last_ends_run, clk, rst_n, (stat.emit && stat.last) |=> !stat.busy)
  // A held result flagged last is always the newline.
  `I2R_ASSERT_NEVER(a_last_is_nl, clk, rst_n, out_valid_r && out_last_r && out_char_code_r != CH_NL)
  // Never emit into a full, stalled output register.
  `I2R_ASSERT_NEVER(a_no_overrun, clk, rst_n, stat.emit && out_valid_r && !out_ready)

endmodule
